// ----- rtl/atrm_pkg.sv -----
// ----------------------------------------------------------------------------
// atrm_pkg
// Shared types and constants for the altitude timed release motor block.
// ----------------------------------------------------------------------------
package atrm_pkg;

  localparam int unsigned NumGroups  = 3;
  localparam int unsigned NumWindows = 3;

  localparam logic [31:0] ArmWindow    = 32'd10;
  localparam logic [9:0]  FaultOnAfter = 10'd300;
  localparam logic [9:0]  FaultLimit   = 10'd900;

  // register indexes on the configuration port
  localparam logic [2:0] RegGroupA  = 3'd0;
  localparam logic [2:0] RegGroupB  = 3'd1;
  localparam logic [2:0] RegGroupC  = 3'd2;
  localparam logic [2:0] RegWindowA = 3'd3;
  localparam logic [2:0] RegWindowB = 3'd4;
  localparam logic [2:0] RegWindowC = 3'd5;
  localparam logic [2:0] RegEnable  = 3'd6;
  localparam logic [2:0] RegMargin  = 3'd7;

  // altitude group sequence
  typedef enum logic [4:0] {
    GS_IDLE    = 5'b00001,
    GS_ARMED   = 5'b00010,
    GS_CONFIRM = 5'b00100,
    GS_RUN     = 5'b01000,
    GS_DONE    = 5'b10000
  } grp_stage_t;

  typedef struct packed {
    logic [NumGroups-1:0][63:0]  group_setting;
    logic [NumWindows-1:0][63:0] window_setting;
    logic [5:0]                  enable_mask;
    logic [31:0]                 altitude_margin;
  } cfg_t;

  // what one group reports for the current tick
  typedef struct packed {
    logic write;   // group drives the motor level this tick
    logic level;
    logic done;    // group in its done stage after this tick
  } grp_status_t;

endpackage

// ----- rtl/atrm_if.sv -----
// ----------------------------------------------------------------------------
// atrm_tick_if / atrm_result_if
// Valid/ready channels for control ticks and motor results.
// ----------------------------------------------------------------------------
interface atrm_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] altitude;
  logic [31:0] tick_time;
  logic        storage_fault;
  logic        start_request;
  logic [31:0] start_duration;

  modport source (output valid, altitude, tick_time, storage_fault, start_request,
                  start_duration, input ready);
  modport sink (input valid, altitude, tick_time, storage_fault, start_request,
                start_duration, output ready);
endinterface

interface atrm_result_if;
  logic       valid;
  logic       ready;
  logic       motor_on;
  logic [2:0] groups_done;

  modport source (output valid, motor_on, groups_done, input ready);
  modport sink (input valid, motor_on, groups_done, output ready);
endinterface

// ----- rtl/atrm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// atrm_cfg_regs
// APB-style register file holding group, window, enable and margin settings.
// ----------------------------------------------------------------------------
module atrm_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [5:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output logic           pready,
  output atrm_pkg::cfg_t cfg
);
  import atrm_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegGroupA:  cfg.group_setting[0]  <= pwdata;
        RegGroupB:  cfg.group_setting[1]  <= pwdata;
        RegGroupC:  cfg.group_setting[2]  <= pwdata;
        RegWindowA: cfg.window_setting[0] <= pwdata;
        RegWindowB: cfg.window_setting[1] <= pwdata;
        RegWindowC: cfg.window_setting[2] <= pwdata;
        RegEnable:  cfg.enable_mask       <= pwdata[5:0];
        RegMargin:  cfg.altitude_margin   <= pwdata[31:0];
        default:    cfg.altitude_margin   <= cfg.altitude_margin;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegGroupA:  prdata = cfg.group_setting[0];
      RegGroupB:  prdata = cfg.group_setting[1];
      RegGroupC:  prdata = cfg.group_setting[2];
      RegWindowA: prdata = cfg.window_setting[0];
      RegWindowB: prdata = cfg.window_setting[1];
      RegWindowC: prdata = cfg.window_setting[2];
      RegEnable:  prdata = {58'd0, cfg.enable_mask};
      RegMargin:  prdata = {32'd0, cfg.altitude_margin};
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- rtl/atrm_group.sv -----
// ----------------------------------------------------------------------------
// atrm_group
// One altitude release group: arm, confirm on changing readings, timed run.
// ----------------------------------------------------------------------------
module atrm_group (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  enable,
  input  logic                  commit,
  input  logic [31:0]           altitude,
  input  logic [31:0]           tick_time,
  input  logic [63:0]           setting,
  input  logic [31:0]           margin,
  output atrm_pkg::grp_status_t status
);
  import atrm_pkg::*;

  grp_stage_t  stage, stage_mid, stage_next;
  logic [31:0] stamp, stamp_mid, last_alt;
  logic [31:0] threshold, duration;
  logic [32:0] alt_sum;
  logic        at_height, in_window, changed, run_live;

  assign threshold = setting[31:0];
  assign duration  = setting[63:32];

  // exact sum, no wrap
  assign alt_sum   = {altitude[31], altitude} + {margin[31], margin};
  assign at_height = $signed(alt_sum) >= $signed({threshold[31], threshold});
  assign in_window = tick_time < (stamp + ArmWindow);
  assign changed   = altitude != last_alt;

  always_comb begin
    stage_mid = stage;
    stamp_mid = stamp;
    unique case (stage)
      GS_IDLE: begin
        if (at_height) begin
          stage_mid = GS_ARMED;
          stamp_mid = tick_time;
        end
      end
      GS_ARMED: begin
        if (!at_height || !in_window) begin
          stage_mid = GS_IDLE;
        end else if (changed) begin
          stage_mid = GS_CONFIRM;
        end
      end
      GS_CONFIRM: begin
        if (!at_height || !in_window) begin
          stage_mid = GS_IDLE;
        end else if (changed) begin
          stage_mid = GS_RUN;
          stamp_mid = tick_time;
        end
      end
      GS_RUN, GS_DONE: begin
        stage_mid = stage;
      end
      default: begin
        stage_mid = GS_IDLE;
      end
    endcase
  end

  assign run_live = tick_time < (stamp_mid + duration);

  always_comb begin
    stage_next   = stage_mid;
    status.write = 1'b0;
    status.level = 1'b0;
    if (stage_mid == GS_RUN) begin
      status.write = 1'b1;
      status.level = run_live;
      if (!run_live) begin
        stage_next = GS_DONE;
      end
    end
    if (!enable) begin
      stage_next   = stage;
      status.write = 1'b0;
    end
    status.done = stage_next == GS_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage    <= GS_IDLE;
      stamp    <= '0;
      last_alt <= '0;
    end else if (commit && enable) begin
      stage    <= stage_next;
      stamp    <= stamp_mid;
      last_alt <= altitude;
    end
  end

endmodule

// ----- rtl/altitude_timed_release_motor.sv -----
// ----------------------------------------------------------------------------
// altitude_timed_release_motor
// Release motor controller driven by altitude groups, time windows, a storage
// fault fallback and a commanded timed run; one motor level per control tick.
// ----------------------------------------------------------------------------
// Path: an accepted tick beat goes through the tick register, then the result register, to its result beat.
// Throughput: one tick beat per cycle; the tick register and the result
//   register move together, so the result register only stalls the input
//   when it is full and not being taken.
// Reset: synchronous, active high; clears settings, group stages, fault count,
//   commanded run and the motor level (off). No clearing pass.
module altitude_timed_release_motor (
  input  logic               clk,
  input  logic               rst,
  atrm_tick_if.sink          tick,
  atrm_result_if.source      result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import atrm_pkg::*;

  cfg_t cfg;

  // tick register
  logic        tick_vld;
  logic [31:0] q_alt, q_tick, q_dur;
  logic        q_fault, q_req;
  logic        advance;

  // block state
  logic        motor_level, motor_next;
  logic [9:0]  fault_ticks, fault_next;
  logic        run_active, run_active_next;
  logic [31:0] run_stamp, run_stamp_next, run_length, run_length_next;

  grp_status_t [NumGroups-1:0] grp;
  logic [NumWindows-1:0]       win_on;
  logic [10:0]                 fault_inc;
  logic                        fault_write, fault_level;
  logic                        run_write, run_level;
  logic [31:0]                 run_stamp_eff, run_length_eff;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  atrm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // --------------------------------------------------------------------------
  // Handshake: the tick register drains into the result register whenever the
  // result register is empty or its beat is taken this cycle.
  // --------------------------------------------------------------------------
  assign advance    = tick_vld && (!result.valid || result.ready);
  assign tick.ready = !tick_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_vld <= 1'b0;
    end else if (tick.ready) begin
      tick_vld <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      q_alt   <= tick.altitude;
      q_tick  <= tick.tick_time;
      q_fault <= tick.storage_fault;
      q_req   <= tick.start_request;
      q_dur   <= tick.start_duration;
    end
  end

  // --------------------------------------------------------------------------
  // Altitude groups, state committed only when the tick moves on
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    atrm_group u_grp (
      .clk       (clk),
      .rst       (rst),
      .enable    (cfg.enable_mask[g]),
      .commit    (advance),
      .altitude  (q_alt),
      .tick_time (q_tick),
      .setting   (cfg.group_setting[g]),
      .margin    (cfg.altitude_margin),
      .status    (grp[g])
    );
  end

  // --------------------------------------------------------------------------
  // Absolute time windows: open strictly between start and start + length
  // (sum wraps at 32 bits)
  // --------------------------------------------------------------------------
  for (genvar w = 0; w < NumWindows; w++) begin : g_win
    assign win_on[w] = (q_tick > cfg.window_setting[w][31:0]) &&
                       (q_tick < (cfg.window_setting[w][31:0] +
                                  cfg.window_setting[w][63:32]));
  end

  // --------------------------------------------------------------------------
  // Storage fault fallback: count saturates at the limit; on above the
  // threshold, off at the limit, no opinion below.
  // --------------------------------------------------------------------------
  assign fault_inc = {1'b0, fault_ticks} + 11'd1;

  always_comb begin
    fault_next  = fault_ticks;
    fault_write = 1'b0;
    fault_level = 1'b0;
    if (q_fault) begin
      if (fault_inc >= {1'b0, FaultLimit}) begin
        fault_next  = FaultLimit;
        fault_write = 1'b1;
      end else begin
        fault_next = fault_inc[9:0];
        if (fault_inc > {1'b0, FaultOnAfter}) begin
          fault_write = 1'b1;
          fault_level = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Commanded run: a request (re)starts it from this tick
  // --------------------------------------------------------------------------
  assign run_stamp_eff  = q_req ? q_tick : run_stamp;
  assign run_length_eff = q_req ? q_dur  : run_length;

  always_comb begin
    run_active_next = run_active | q_req;
    run_stamp_next  = run_stamp_eff;
    run_length_next = run_length_eff;
    run_write       = run_active_next;
    run_level       = 1'b0;
    if (run_active_next) begin
      if (q_tick < (run_stamp_eff + run_length_eff)) begin
        run_level = 1'b1;
      end else begin
        run_active_next = 1'b0;
        run_stamp_next  = '0;
        run_length_next = '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Motor level: the last source to write in tick order wins, else hold
  // --------------------------------------------------------------------------
  always_comb begin
    priority if (run_write) begin
      motor_next = run_level;
    end else if (fault_write) begin
      motor_next = fault_level;
    end else if (cfg.enable_mask[5]) begin
      motor_next = win_on[2];
    end else if (cfg.enable_mask[4]) begin
      motor_next = win_on[1];
    end else if (cfg.enable_mask[3]) begin
      motor_next = win_on[0];
    end else if (grp[2].write) begin
      motor_next = grp[2].level;
    end else if (grp[1].write) begin
      motor_next = grp[1].level;
    end else if (grp[0].write) begin
      motor_next = grp[0].level;
    end else begin
      motor_next = motor_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_level <= 1'b0;
      fault_ticks <= '0;
      run_active  <= 1'b0;
      run_stamp   <= '0;
      run_length  <= '0;
    end else if (advance) begin
      motor_level <= motor_next;
      fault_ticks <= fault_next;
      run_active  <= run_active_next;
      run_stamp   <= run_stamp_next;
      run_length  <= run_length_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.motor_on    <= motor_next;
      result.groups_done <= {grp[2].done, grp[1].done, grp[0].done};
    end
  end

endmodule
